// File: hw/rtl/mcw_pkg.sv
`default_nettype none
package mcw_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int NUM_SLOTS    = 8;
    localparam int SLOT_W       = 3;
    localparam int TIME_W       = 64;
    localparam int IVL_W        = 32;
    localparam int MASK_W       = 8;

    localparam logic [MASK_W-1:0] FULL_BYTE = 8'hFF;
    localparam logic [MASK_W-1:0] CHAN_MASK =
        MASK_W'(((MASK_W+1)'(1) << NUM_CHANNELS) - (MASK_W+1)'(1)) & FULL_BYTE;
    localparam logic [SLOT_W:0]   NUM_CH_V  = (SLOT_W+1)'(NUM_CHANNELS);
    localparam logic [SLOT_W-1:0] LAST_CH   = SLOT_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_KICK    = 2'd2,
        CMD_TICK    = 2'd3
    } mcw_op_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [IVL_W-1:0]  interval;
    } mcw_in_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] grant_slot;
        logic              none_free;
        logic              expired;
        logic [MASK_W-1:0] expired_mask;
    } mcw_out_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic tick_start;
        logic scan_step;
        logic load_out;
    } mcw_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic scan_last;
    } mcw_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/multi_channel_watchdog.sv
// Acquire, release and kick are decoded and executed, then raise their result word; a tick
// first advances time, then makes one deadline compare per channel in the scan state.
// A new word is not accepted until the result of the last one is in the output register;
// the per-channel scan goes through the single 64-bit comparator.
// Reset (rst_n low, asynchronous): all channels free and disarmed, time at zero,
// no result pending.
`default_nettype none
module multi_channel_watchdog
    import mcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire mcw_in_t  item,
    output logic          result_valid,
    input  wire logic     result_stall,
    output mcw_out_t      result
);

    mcw_cmd_t    cmd;
    mcw_status_t status;

    mcw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    mcw_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid || !result_stall))
        else $error("result word overwritten while pending");

    a_expired_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.expired == (result.expired_mask != '0)))
        else $error("expired flag disagrees with expiry mask");

    a_grant_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.granted && result.none_free))
        else $error("grant and none_free both set");

    a_acq_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.granted || result.none_free)) |-> (result.expired_mask == '0))
        else $error("acquire result carries expiry bits");

endmodule
`default_nettype wire

// File: hw/rtl/mcw_ctrl.sv
`default_nettype none
module mcw_ctrl
    import mcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    output logic             result_valid,
    input  wire logic        result_stall,
    input  wire mcw_status_t status,
    output mcw_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        // drop the pending word once the sink takes it
        valid_next = valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_tick)
                begin
                    cmd.tick_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!valid_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;

endmodule
`default_nettype wire

// File: hw/rtl/mcw_dp.sv
`default_nettype none
module mcw_dp
    import mcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mcw_in_t  item,
    input  wire mcw_cmd_t cmd,
    output mcw_status_t   status,
    output mcw_out_t      result
);

    mcw_in_t            item_reg;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [MASK_W-1:0]  alloc_reg, alloc_next;
    logic [MASK_W-1:0]  armed_reg, armed_next;
    logic [MASK_W-1:0]  live_reg, live_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [TIME_W-1:0]  deadline_reg [NUM_SLOTS];
    mcw_out_t           res_reg, res_next;
    mcw_out_t           result_reg;

    logic [MASK_W-1:0]  free_mask;
    logic               found;
    logic [SLOT_W-1:0]  pick;
    logic               slot_ok;
    logic               kick_wr;
    logic [TIME_W-1:0]  kick_sum;

    // lowest free channel
    always_comb
    begin
        free_mask = ~alloc_reg & CHAN_MASK;
        found     = 1'b0;
        pick      = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                found = 1'b1;
                pick  = SLOT_W'(i);
            end
        end
    end

    assign slot_ok  = ({1'b0, item_reg.slot} < NUM_CH_V);
    assign kick_wr  = cmd.exec && (item_reg.cmd == CMD_KICK) && slot_ok;
    assign kick_sum = now_reg + {{(TIME_W-IVL_W){1'b0}}, item_reg.interval};

    always_comb
    begin
        now_next   = now_reg;
        alloc_next = alloc_reg;
        armed_next = armed_reg;
        live_next  = live_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;

        if (cmd.exec)
        begin
            res_next = '0;
            case (item_reg.cmd)
                CMD_ACQUIRE:
                begin
                    res_next.none_free = !found;
                    if (found)
                    begin
                        res_next.granted    = 1'b1;
                        res_next.grant_slot = pick;
                        alloc_next[pick]    = 1'b1;
                        armed_next[pick]    = 1'b0;
                    end
                end
                CMD_RELEASE:
                begin
                    if (slot_ok)
                    begin
                        alloc_next[item_reg.slot] = 1'b0;
                        armed_next[item_reg.slot] = 1'b0;
                    end
                end
                CMD_KICK:
                begin
                    if (slot_ok)
                    begin
                        armed_next[item_reg.slot] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.tick_start)
        begin
            now_next  = now_reg + TIME_W'(1);
            res_next  = '0;
            idx_next  = '0;
            live_next = alloc_reg & armed_reg & CHAN_MASK;
        end

        // one channel compare per cycle against the advanced time
        if (cmd.scan_step)
        begin
            if (live_reg[idx_reg] && (now_reg > deadline_reg[idx_reg]))
            begin
                res_next.expired_mask[idx_reg] = 1'b1;
                res_next.expired               = 1'b1;
            end
            idx_next = idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            alloc_reg <= '0;
            armed_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            now_reg   <= now_next;
            alloc_reg <= alloc_next;
            armed_reg <= armed_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        live_reg <= live_next;
        if (cmd.load_in)
        begin
            item_reg <= item;
        end
        if (kick_wr)
        begin
            deadline_reg[item_reg.slot] <= kick_sum;
        end
        if (cmd.load_out)
        begin
            result_reg <= res_reg;
        end
    end

    assign status.is_tick   = (item_reg.cmd == CMD_TICK);
    assign status.scan_last = (idx_reg == LAST_CH);
    assign result           = result_reg;

endmodule
`default_nettype wire
